@@ hw/rtl/kmrs_pkg.sv @@
// Shared types and constants of the keyed mailbox ring set.
`default_nettype none
package kmrs_pkg;

   // default sizes
   localparam int NUM_BOXES_DEF  = 32;
   localparam int RING_DEPTH_DEF = 16;

   // key value that create refuses as reserved
   localparam logic [31:0] FREE_KEY = 32'hFFFF_FFFF;

   // request operations
   localparam logic [1:0] FUNC_CREATE = 2'd0;
   localparam logic [1:0] FUNC_SEND   = 2'd1;
   localparam logic [1:0] FUNC_RECV   = 2'd2;

   // response status codes
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BAD_ID   = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NO_BOX   = 3'd4,
      ST_RESERVED = 3'd5
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;     // latch request fields
      logic       scan_clear;  // start key scan at box zero
      logic       scan_next;   // advance key scan
      logic       claim;       // claim the scanned box
      logic       meta_load;   // latch ring base of the addressed box
      logic       send_wr;     // append message, update pointers
      logic       recv_rd;     // read oldest message, update pointers
      logic       set_rsp;     // load response registers
      status_type rsp_status;
      logic       rsp_box;     // response carries the scanned box index
      logic       rsp_data;    // response carries the ring read data
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_create;
      logic is_send;
      logic is_recv;
      logic key_reserved;
      logic id_bad;
      logic key_match;
      logic box_free;
      logic scan_last;
      logic ring_full;
      logic ring_empty;
   } dp_stat_type;

endpackage
`default_nettype wire

@@ hw/rtl/keyed_mailbox_ring_set_core.sv @@
// Keyed mailbox ring set: top level joining controller and datapath.
//
// A set of NUM_BOXES mailboxes, each a ring of RING_DEPTH 32-bit words.
// Request channel: a request is taken at a rising edge with start high and
// busy low; req_func selects create by key, send or receive.
// Response channel: exactly one response per request, shown for one cycle
// with rsp_valid high; the receiver takes it at the end of that cycle and
// cannot hold it off.
// Bad box id, reserved key and unused operations are answered from the decode
// state; send, ring full and ring empty after a pointer table read; receive
// after a pointer table read, then a ring read; create after a key scan that
// does one key table read and compare per box it visits, up to NUM_BOXES.
// busy stays high until the response cycle is over; the next request is
// taken in the cycle after it at the earliest, so only one request is in
// flight at a time.
// Reset frees every box and clears every ring's pointers at once through
// per-box valid bits; no clearing pass is needed. Ring contents are not
// reset.
`default_nettype none
module keyed_mailbox_ring_set_core #(
   parameter int NUM_BOXES  = kmrs_pkg::NUM_BOXES_DEF,
   parameter int RING_DEPTH = kmrs_pkg::RING_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_func,
   input  wire logic signed [31:0] req_key,
   input  wire logic [5:0]         req_box_id,
   input  wire logic signed [31:0] req_message,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [4:0]              rsp_result_box,
   output logic signed [31:0]      rsp_received
);

   kmrs_pkg::dp_cmd_type  cmd;
   kmrs_pkg::dp_stat_type stat;

   // sequencing
   kmrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and response
   kmrs_dp #(
      .NUM_BOXES  (NUM_BOXES),
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_box_id     (req_box_id),
      .req_message    (req_message),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_result_box (rsp_result_box),
      .rsp_received   (rsp_received)
   );

endmodule
`default_nettype wire

@@ hw/rtl/kmrs_ram.sv @@
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module kmrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ hw/rtl/kmrs_ctrl.sv @@
// Controller state machine of the keyed mailbox ring set.
`default_nettype none
module kmrs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output logic                      rsp_valid,
   input  wire kmrs_pkg::dp_stat_type stat,
   output kmrs_pkg::dp_cmd_type      cmd
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b000_0001,
      S_DECODE = 7'b000_0010,
      S_SCAN   = 7'b000_0100,
      S_CHECK  = 7'b000_1000,
      S_EVAL   = 7'b001_0000,
      S_RING   = 7'b010_0000,
      S_DONE   = 7'b100_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rsp_status = kmrs_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            if (stat.is_create) begin
               if (stat.key_reserved) begin
                  cmd.set_rsp = 1'b1;
                  cmd.rsp_status = kmrs_pkg::ST_RESERVED;
               end else begin
                  cmd.scan_clear = 1'b1;
                  state_in = S_SCAN;
               end
            end else if (stat.is_send || stat.is_recv) begin
               if (stat.id_bad) begin
                  cmd.set_rsp = 1'b1;
                  cmd.rsp_status = kmrs_pkg::ST_BAD_ID;
               end else begin
                  cmd.meta_load = 1'b1;
                  state_in = S_EVAL;
               end
            end else begin
               // unused operation answers ok with zero fields
               cmd.set_rsp = 1'b1;
            end
         end
         S_SCAN: begin
            // key read of the current box is under way
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.key_match) begin
               cmd.set_rsp = 1'b1;
               cmd.rsp_box = 1'b1;
               state_in = S_DONE;
            end else if (stat.box_free) begin
               cmd.claim = 1'b1;
               cmd.set_rsp = 1'b1;
               cmd.rsp_box = 1'b1;
               state_in = S_DONE;
            end else if (stat.scan_last) begin
               cmd.set_rsp = 1'b1;
               cmd.rsp_status = kmrs_pkg::ST_NO_BOX;
               state_in = S_DONE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_EVAL: begin
            state_in = S_DONE;
            if (stat.is_send) begin
               cmd.set_rsp = 1'b1;
               if (stat.ring_full) begin
                  cmd.rsp_status = kmrs_pkg::ST_FULL;
               end else begin
                  cmd.send_wr = 1'b1;
               end
            end else if (stat.ring_empty) begin
               cmd.set_rsp = 1'b1;
               cmd.rsp_status = kmrs_pkg::ST_EMPTY;
            end else begin
               cmd.recv_rd = 1'b1;
               state_in = S_RING;
            end
         end
         S_RING: begin
            cmd.set_rsp = 1'b1;
            cmd.rsp_data = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule
`default_nettype wire

@@ hw/rtl/kmrs_dp.sv @@
// Datapath of the keyed mailbox ring set: key table, ring pointers, ring store.
`default_nettype none
module kmrs_dp #(
   parameter int NUM_BOXES  = kmrs_pkg::NUM_BOXES_DEF,
   parameter int RING_DEPTH = kmrs_pkg::RING_DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [1:0]           req_func,
   input  wire logic signed [31:0]   req_key,
   input  wire logic [5:0]           req_box_id,
   input  wire logic signed [31:0]   req_message,
   input  wire kmrs_pkg::dp_cmd_type cmd,
   output kmrs_pkg::dp_stat_type     stat,
   output logic [2:0]                rsp_status,
   output logic [4:0]                rsp_result_box,
   output logic signed [31:0]        rsp_received
);

   localparam int BOX_W  = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
   localparam int PTR_W  = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int META_W = 2 * PTR_W + CNT_W;
   localparam int RING_N = NUM_BOXES * RING_DEPTH;
   localparam int RA_W   = $clog2(RING_N);

   // latched request
   logic [1:0]  func_ff;
   logic [31:0] key_ff;
   logic [5:0]  id_ff;
   logic [31:0] msg_ff;

   logic [BOX_W-1:0] idx_ff;
   logic [RA_W-1:0]  base_ff;
   logic [NUM_BOXES-1:0] claimed_ff;
   logic [NUM_BOXES-1:0] meta_valid_ff;

   logic [2:0]  status_ff;
   logic [4:0]  box_ff;
   logic [31:0] recv_ff;

   logic [BOX_W-1:0]  id_idx;
   logic [31:0]       key_rd;
   logic [META_W-1:0] meta_rd;
   logic [META_W-1:0] meta_eff;
   logic [META_W-1:0] meta_wr;
   logic [PTR_W-1:0]  rp;
   logic [PTR_W-1:0]  wp;
   logic [CNT_W-1:0]  cnt;
   logic [RA_W-1:0]   ring_wr_addr;
   logic [RA_W-1:0]   ring_rd_addr;
   logic [31:0]       ring_rd;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(RING_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign id_idx = BOX_W'(id_ff);

   // request capture, scan index and ring base
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         key_ff  <= req_key;
         id_ff   <= req_box_id;
         msg_ff  <= req_message;
      end
      if (cmd.scan_clear) begin
         idx_ff <= '0;
      end else if (cmd.scan_next) begin
         idx_ff <= idx_ff + BOX_W'(1);
      end
      if (cmd.meta_load) begin
         base_ff <= RA_W'(32'(id_idx) * 32'(RING_DEPTH));
      end
   end

   // per box valid bits: claimed key, written pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         claimed_ff    <= '0;
         meta_valid_ff <= '0;
      end else begin
         if (cmd.claim) begin
            claimed_ff[idx_ff]    <= 1'b1;
            meta_valid_ff[idx_ff] <= 1'b0;
         end
         if (cmd.send_wr || cmd.recv_rd) begin
            meta_valid_ff[id_idx] <= 1'b1;
         end
      end
   end

   // key table
   kmrs_ram #(.WIDTH(32), .DEPTH(NUM_BOXES)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.claim),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_addr (idx_ff),
      .rd_data (key_rd)
   );

   // pointer table: read pointer, write pointer, fill count
   kmrs_ram #(.WIDTH(META_W), .DEPTH(NUM_BOXES)) u_meta_ram (
      .clock   (clock),
      .wr_en   (cmd.send_wr || cmd.recv_rd),
      .wr_addr (id_idx),
      .wr_data (meta_wr),
      .rd_addr (id_idx),
      .rd_data (meta_rd)
   );

   assign meta_eff = meta_valid_ff[id_idx] ? meta_rd : '0;
   assign rp  = meta_eff[META_W-1 -: PTR_W];
   assign wp  = meta_eff[CNT_W +: PTR_W];
   assign cnt = meta_eff[CNT_W-1:0];

   // pointer update for append or removal
   always_comb begin
      if (cmd.send_wr) begin
         meta_wr = {rp, next_ptr(wp), cnt + CNT_W'(1)};
      end else begin
         meta_wr = {next_ptr(rp), wp, cnt - CNT_W'(1)};
      end
   end

   assign ring_wr_addr = base_ff + RA_W'(wp);
   assign ring_rd_addr = base_ff + RA_W'(rp);

   // message rings
   kmrs_ram #(.WIDTH(32), .DEPTH(RING_N)) u_ring_ram (
      .clock   (clock),
      .wr_en   (cmd.send_wr),
      .wr_addr (ring_wr_addr),
      .wr_data (msg_ff),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd)
   );

   // status toward the controller
   always_comb begin
      stat.is_create    = (func_ff == kmrs_pkg::FUNC_CREATE);
      stat.is_send      = (func_ff == kmrs_pkg::FUNC_SEND);
      stat.is_recv      = (func_ff == kmrs_pkg::FUNC_RECV);
      stat.key_reserved = (key_ff == kmrs_pkg::FREE_KEY);
      stat.id_bad       = (32'(id_ff) >= 32'(NUM_BOXES));
      stat.key_match    = claimed_ff[idx_ff] && (key_rd == key_ff);
      stat.box_free     = !claimed_ff[idx_ff];
      stat.scan_last    = (idx_ff == BOX_W'(NUM_BOXES - 1));
      stat.ring_full    = (cnt == CNT_W'(RING_DEPTH));
      stat.ring_empty   = (cnt == '0);
   end

   // response registers
   always_ff @(posedge clock) begin
      if (cmd.set_rsp) begin
         status_ff <= cmd.rsp_status;
         box_ff    <= cmd.rsp_box ? 5'(idx_ff) : 5'd0;
         recv_ff   <= cmd.rsp_data ? ring_rd : 32'd0;
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_result_box = box_ff;
   assign rsp_received   = recv_ff;

endmodule
`default_nettype wire
